// ===== hdl/hdff_pkg.sv =====
// Package for the heat diffusion fire field block.
// Holds constants, the controller state type and the controller to datapath command and status.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hdff_pkg;

  localparam int MAX_COLUMNS_DEF = 16;
  localparam int MAX_ROWS_DEF    = 16;

  localparam int HEAT_W  = 8;
  localparam int SEED_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;
  localparam int DIM_W   = 5;

  localparam logic [SEED_W-1:0] SEED_RESET = 16'd1337;
  localparam int SEED_MUL = 2053;
  localparam int SEED_INC = 13849;

  localparam int COOL_BASE  = 2;
  localparam int HEAT_MAX   = 255;
  localparam int COOL_DIV   = 16;
  localparam int SPARK_BASE = 80;
  localparam int SPARK_ROWS = 3;
  localparam int SPARK_HEAT = 160;
  localparam int SPARK_SPAN = 95;
  localparam int MIN_ROWS   = 3;
  localparam int RND_SH     = 8;

  // Reciprocal of three for an 8-bit and a 10-bit dividend.
  localparam int RECIP3_8_MUL  = 171;
  localparam int RECIP3_8_SH   = 9;
  localparam int RECIP3_10_MUL = 683;
  localparam int RECIP3_10_SH  = 11;

  localparam logic [CFG_DAT_W-1:0] SCALE_RESET = 8'd128;
  localparam logic [CFG_DAT_W-1:0] SPEED_RESET = 8'd128;
  localparam logic [DIM_W-1:0]     COLS_RESET  = 5'd16;
  localparam logic [DIM_W-1:0]     ROWS_RESET  = 5'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_FLAME_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLAME_SPEED  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS_USED = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED    = 2'd3;

  localparam logic OP_STEP = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_CELL_LOAD, S_COOL_RD, S_COOL_WR, S_DIF_INIT, S_DIF_LOAD, S_DIF_RD,
    S_DIF_WR, S_SPK_DRAW, S_SPK_TEST, S_SPK_PICK, S_SPK_RD, S_SPK_WR, S_NEXT, S_FIN
  } state_t;

  typedef enum logic [3:0] {
    DP_NOP, DP_CLEAR, DP_STEP_INIT, DP_CELL_RD, DP_CELL_LOAD, DP_COOL_RD, DP_COOL_WR,
    DP_DIF_INIT, DP_DIF_LOAD, DP_DIF_RD, DP_DIF_WR, DP_SEED_ADV, DP_SPK_PICK, DP_SPK_RD,
    DP_SPK_WR, DP_COL_NEXT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic no_cols;
    logic last_col;
    logic last_cool;
    logic last_dif;
    logic spark_hit;
  } sts_t;

endpackage

`default_nettype wire

// ===== hdl/hdff_dp.sv =====
// Datapath of the heat diffusion fire field: heat memory, random generator, counters,
// configuration registers and the result register. Depends on hdff_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hdff_dp
  import hdff_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cmd_t                 cmd,
  output sts_t                      sts,
  input  wire logic [3:0]           in_column,
  input  wire logic [3:0]           in_row,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data,
  output logic [HEAT_W-1:0]         out_heat_value
);

  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RIW   = $clog2(MAX_ROWS);
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int CCW   = $clog2(MAX_COLUMNS + 1);

  logic [HEAT_W-1:0] mem [DEPTH];

  logic [CFG_DAT_W-1:0] cfg_scale_r, cfg_speed_r;
  logic [DIM_W-1:0]     cfg_cols_r, cfg_rows_r;

  logic [SEED_W-1:0] seed_r, seed_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [AW-1:0]     base_r, base_nxt;
  logic [CCW-1:0]    ccnt_r, ccnt_nxt;
  logic [RIW-1:0]    row_r, row_nxt;
  logic [1:0]        spk_row_r, spk_row_nxt;
  logic [HEAT_W-1:0] a_r, a_nxt;
  logic [HEAT_W-1:0] res_r, res_nxt;
  logic              inr_r, inr_nxt;
  logic [HEAT_W-1:0] rdata_r;
  logic [HEAT_W-1:0] out_heat_value_r;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [HEAT_W-1:0] mem_wdata;

  logic [CCW-1:0]    cols_eff;
  logic [RCW-1:0]    rows_eff;
  logic [27:0]       seed_prod;
  logic [SEED_W-1:0] seed_adv;
  logic [7:0]        rand_byte;
  logic [7:0]        inv_scale;
  logic [4:0]        cool_lim;
  logic [12:0]       cool_prod;
  logic [4:0]        cool_amt;
  logic [HEAT_W-1:0] cooled;
  logic [15:0]       spd_prod;
  logic [7:0]        spark_lim;
  logic [9:0]        r3_prod;
  logic [14:0]       r95_prod;
  logic [HEAT_W-1:0] boost;
  logic [8:0]        sat_sum;
  logic [HEAT_W-1:0] sparked;
  logic [9:0]        dsum;
  logic [19:0]       dprod;
  logic [HEAT_W-1:0] diffused;
  logic [31:0]       cell_lin;
  logic [AW-1:0]     cell_addr;
  logic              cell_ok;
  logic [AW-1:0]     cur_addr;

  always_comb begin
    if (32'(cfg_cols_r) > 32'(MAX_COLUMNS)) begin
      cols_eff = CCW'(MAX_COLUMNS);
    end else begin
      cols_eff = CCW'(cfg_cols_r);
    end
    if (32'(cfg_rows_r) > 32'(MAX_ROWS)) begin
      rows_eff = RCW'(MAX_ROWS);
    end else if (32'(cfg_rows_r) < 32'(MIN_ROWS)) begin
      rows_eff = RCW'(MIN_ROWS);
    end else begin
      rows_eff = RCW'(cfg_rows_r);
    end
  end

  assign seed_prod = 28'(seed_r) * 28'(SEED_MUL) + 28'(SEED_INC);
  assign seed_adv  = seed_prod[SEED_W-1:0];
  assign rand_byte = seed_r[7:0] + seed_r[15:8];

  assign inv_scale = 8'(HEAT_MAX) - cfg_scale_r;
  assign cool_lim  = 5'(COOL_BASE) + 5'(inv_scale / 8'(COOL_DIV));
  assign cool_prod = 13'(rand_byte) * 13'(cool_lim);
  assign cool_amt  = cool_prod[12:8];
  assign cooled    = (rdata_r > 8'(cool_amt)) ? (rdata_r - 8'(cool_amt)) : '0;

  assign spd_prod  = 16'(cfg_speed_r) * 16'(RECIP3_8_MUL);
  assign spark_lim = 8'(SPARK_BASE) + 8'(spd_prod >> RECIP3_8_SH);

  assign r3_prod  = 10'(rand_byte) * 10'(SPARK_ROWS);
  assign r95_prod = 15'(rand_byte) * 15'(SPARK_SPAN);
  assign boost    = 8'(SPARK_HEAT) + 8'(r95_prod >> RND_SH);
  assign sat_sum  = {1'b0, rdata_r} + {1'b0, boost};
  assign sparked  = sat_sum[8] ? 8'(HEAT_MAX) : sat_sum[7:0];

  assign dsum     = 10'(a_r) + {1'b0, rdata_r, 1'b0};
  assign dprod    = 20'(dsum) * 20'(RECIP3_10_MUL);
  assign diffused = 8'(dprod >> RECIP3_10_SH);

  assign cell_lin  = 32'(in_column) * 32'(MAX_ROWS) + 32'(in_row);
  assign cell_addr = cell_lin[AW-1:0];
  assign cell_ok   = (32'(in_column) < 32'(MAX_COLUMNS)) && (32'(in_row) < 32'(MAX_ROWS));
  assign cur_addr  = base_r + AW'(row_r);

  always_comb begin
    seed_nxt    = seed_r;
    clr_nxt     = clr_r;
    base_nxt    = base_r;
    ccnt_nxt    = ccnt_r;
    row_nxt     = row_r;
    spk_row_nxt = spk_row_r;
    a_nxt       = a_r;
    res_nxt     = res_r;
    inr_nxt     = inr_r;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = cur_addr;
    mem_raddr   = cur_addr;
    mem_wdata   = cooled;
    unique case (cmd.op)
      DP_NOP: begin
      end
      DP_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
      end
      DP_STEP_INIT: begin
        base_nxt = '0;
        ccnt_nxt = '0;
        row_nxt  = '0;
        res_nxt  = '0;
      end
      DP_CELL_RD: begin
        mem_re    = 1'b1;
        mem_raddr = cell_addr;
        inr_nxt   = cell_ok;
      end
      DP_CELL_LOAD: begin
        res_nxt = inr_r ? rdata_r : '0;
      end
      DP_COOL_RD: begin
        mem_re   = 1'b1;
        seed_nxt = seed_adv;
      end
      DP_COOL_WR: begin
        mem_we    = 1'b1;
        mem_wdata = cooled;
        row_nxt   = row_r + RIW'(1);
      end
      DP_DIF_INIT: begin
        mem_re    = 1'b1;
        mem_raddr = base_r + AW'(rows_eff - RCW'(2));
        row_nxt   = RIW'(rows_eff - RCW'(1));
      end
      DP_DIF_LOAD: begin
        a_nxt = rdata_r;
      end
      DP_DIF_RD: begin
        mem_re    = 1'b1;
        mem_raddr = base_r + AW'(row_r - RIW'(2));
      end
      DP_DIF_WR: begin
        mem_we    = 1'b1;
        mem_wdata = diffused;
        a_nxt     = rdata_r;
        row_nxt   = row_r - RIW'(1);
      end
      DP_SEED_ADV: begin
        seed_nxt = seed_adv;
      end
      DP_SPK_PICK: begin
        spk_row_nxt = r3_prod[9:8];
        seed_nxt    = seed_adv;
      end
      DP_SPK_RD: begin
        mem_re    = 1'b1;
        mem_raddr = base_r + AW'(spk_row_r);
      end
      DP_SPK_WR: begin
        mem_we    = 1'b1;
        mem_waddr = base_r + AW'(spk_row_r);
        mem_wdata = sparked;
      end
      DP_COL_NEXT: begin
        base_nxt = base_r + AW'(MAX_ROWS);
        ccnt_nxt = ccnt_r + CCW'(1);
        row_nxt  = '0;
      end
    endcase
  end

  always_comb begin
    sts.clr_done  = (clr_r == AW'(DEPTH - 1));
    sts.no_cols   = (cfg_cols_r == '0);
    sts.last_col  = ((32'(ccnt_r) + 32'd1) >= 32'(cols_eff));
    sts.last_cool = (row_r == RIW'(rows_eff - RCW'(1)));
    sts.last_dif  = (row_r == RIW'(2));
    sts.spark_hit = (rand_byte < spark_lim);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= SEED_RESET;
      clr_r       <= '0;
      cfg_scale_r <= SCALE_RESET;
      cfg_speed_r <= SPEED_RESET;
      cfg_cols_r  <= COLS_RESET;
      cfg_rows_r  <= ROWS_RESET;
    end else begin
      seed_r <= seed_nxt;
      clr_r  <= clr_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FLAME_SCALE:  cfg_scale_r <= cfg_data;
          CFG_FLAME_SPEED:  cfg_speed_r <= cfg_data;
          CFG_COLUMNS_USED: cfg_cols_r  <= cfg_data[DIM_W-1:0];
          CFG_ROWS_USED:    cfg_rows_r  <= cfg_data[DIM_W-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    base_r    <= base_nxt;
    ccnt_r    <= ccnt_nxt;
    row_r     <= row_nxt;
    spk_row_r <= spk_row_nxt;
    a_r       <= a_nxt;
    res_r     <= res_nxt;
    inr_r     <= inr_nxt;
    if (cmd.out_load) begin
      out_heat_value_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  assign out_heat_value = out_heat_value_r;

`ifndef SYNTH
  a_waddr_in_field: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (32'(mem_waddr) < 32'(DEPTH)))
    else $error("Heat memory written outside the field.");
  a_spark_row: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_SPK_RD) |-> (spk_row_r != 2'd3))
    else $error("Spark row outside the three base rows.");
  a_dif_row: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_DIF_RD) |-> ((32'(row_r) >= 32'd2) && (32'(row_r) < 32'(rows_eff))))
    else $error("Diffusion row outside the active rows.");
`endif

endmodule

`default_nettype wire

// ===== hdl/hdff_ctrl.sv =====
// Controller of the heat diffusion fire field: sequences clearing, steps and reads,
// and owns the result valid flag. Depends on hdff_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hdff_ctrl
  import hdff_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic in_opcode,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output cmd_t      cmd,
  input  wire sts_t sts
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_opcode == OP_READ) begin
            state_nxt = S_CELL_LOAD;
          end else if (sts.no_cols) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_COOL_RD;
          end
        end
      end
      S_CELL_LOAD: state_nxt = S_FIN;
      S_COOL_RD:   state_nxt = S_COOL_WR;
      S_COOL_WR:   state_nxt = sts.last_cool ? S_DIF_INIT : S_COOL_RD;
      S_DIF_INIT:  state_nxt = S_DIF_LOAD;
      S_DIF_LOAD:  state_nxt = S_DIF_RD;
      S_DIF_RD:    state_nxt = S_DIF_WR;
      S_DIF_WR:    state_nxt = sts.last_dif ? S_SPK_DRAW : S_DIF_RD;
      S_SPK_DRAW:  state_nxt = S_SPK_TEST;
      S_SPK_TEST:  state_nxt = sts.spark_hit ? S_SPK_PICK : S_NEXT;
      S_SPK_PICK:  state_nxt = S_SPK_RD;
      S_SPK_RD:    state_nxt = S_SPK_WR;
      S_SPK_WR:    state_nxt = S_NEXT;
      S_NEXT:      state_nxt = sts.last_col ? S_FIN : S_COOL_RD;
      S_FIN: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    cmd.op       = DP_NOP;
    cmd.out_load = 1'b0;
    in_ready     = 1'b0;
    unique case (state_r)
      S_CLR: cmd.op = DP_CLEAR;
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = (in_opcode == OP_READ) ? DP_CELL_RD : DP_STEP_INIT;
        end
      end
      S_CELL_LOAD: cmd.op = DP_CELL_LOAD;
      S_COOL_RD:   cmd.op = DP_COOL_RD;
      S_COOL_WR:   cmd.op = DP_COOL_WR;
      S_DIF_INIT:  cmd.op = DP_DIF_INIT;
      S_DIF_LOAD:  cmd.op = DP_DIF_LOAD;
      S_DIF_RD:    cmd.op = DP_DIF_RD;
      S_DIF_WR:    cmd.op = DP_DIF_WR;
      S_SPK_DRAW:  cmd.op = DP_SEED_ADV;
      S_SPK_TEST:  cmd.op = sts.spark_hit ? DP_SEED_ADV : DP_NOP;
      S_SPK_PICK:  cmd.op = DP_SPK_PICK;
      S_SPK_RD:    cmd.op = DP_SPK_RD;
      S_SPK_WR:    cmd.op = DP_SPK_WR;
      S_NEXT:      cmd.op = DP_COL_NEXT;
      S_FIN:       cmd.out_load = slot_free;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("Result loaded over one that was not yet taken.");
  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("Second transaction accepted while an item is in progress.");
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> (!in_ready && (cmd.op == DP_CLEAR)))
    else $error("Input taken or field touched during the clearing pass.");
`endif

endmodule

`default_nettype wire

// ===== hdl/heat_diffusion_fire_field_top.sv =====
// Top level of the heat diffusion fire field: joins the controller and the datapath.
// Depends on hdff_pkg, hdff_ctrl and hdff_dp.
//
//   Channel   Direction   Handshake              Payload
//   in_       input       in_valid / in_ready    in_opcode, in_column, in_row
//   out_      output      out_valid / out_ready  out_heat_value
//   cfg_      input       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// After reset the whole field is cleared, one cell a cycle,
// before the first input transaction is taken; configuration writes are taken at once.
// A read loads the addressed cell, or zero outside the field, into the output register.
// A step cools each active column with one random draw per row, diffuses it and may spark
// one of its three base rows. One item is in work at a time; a finished result waits in
// the output register while the next transaction is accepted.
`timescale 1ns / 1ps
`default_nettype none

module heat_diffusion_fire_field_top
  import hdff_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_opcode,
  input  wire logic [3:0]           in_column,
  input  wire logic [3:0]           in_row,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [HEAT_W-1:0]         out_heat_value,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;
  logic cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  hdff_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  hdff_dp #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_column      (in_column),
    .in_row         (in_row),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_heat_value (out_heat_value)
  );

endmodule

`default_nettype wire
